// File: rtl/ipf_pkg.sv
// Package for the IPv4 header packet filter: constants, register indexes and shared types.
`default_nettype none
package ipf_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [5:0] LastPosition  = 6'd63;
  localparam logic [5:0] MinHeaderBase = 6'd20;
  localparam logic [3:0] MinHeaderWords = 4'd5;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] IcmpEchoRequest = 8'd8;
  localparam logic [7:0] LoopbackNet = 8'd127;
  localparam logic [7:0] PrivNetA    = 8'd10;
  localparam logic [7:0] PrivNetB    = 8'd172;
  localparam logic [3:0] PrivNetBHi  = 4'd1;
  localparam logic [7:0] PrivNetC0   = 8'd192;
  localparam logic [7:0] PrivNetC1   = 8'd168;

  localparam logic [31:0] RstBlockedDest   = 32'h0808_0404;
  localparam logic [15:0] RstThrottledPort = 16'd80;
  localparam logic [15:0] RstBlockedPort   = 16'd443;
  localparam logic [3:0]  RstOutEchoPeriod = 4'd3;
  localparam logic [3:0]  RstInEchoPeriod  = 4'd4;
  localparam logic [3:0]  RstPortPeriod    = 4'd2;

  typedef enum logic [2:0] {
    CFG_BLOCKED_DEST   = 3'd0,
    CFG_THROTTLED_PORT = 3'd1,
    CFG_BLOCKED_PORT   = 3'd2,
    CFG_OUT_ECHO_PER   = 3'd3,
    CFG_IN_ECHO_PER    = 3'd4,
    CFG_PORT_PER       = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] blocked_dest;
    logic [15:0] throttled_port;
    logic [15:0] blocked_port;
    logic [3:0]  out_echo_period;
    logic [3:0]  in_echo_period;
    logic [3:0]  port_period;
  } cfg_t;

  // Classified packet handed from the front to the back.
  typedef struct packed {
    logic dst_blocked;
    logic loopback;
    logic fragmented;
    logic bad_proto;
    logic icmp;
    logic echo;
    logic dst_private;
    logic src_private;
    logic hit_throttled;
    logic hit_blocked;
    logic outbound;
  } pkt_class_t;

  function automatic logic is_private(input logic [7:0] first, input logic [7:0] second);
    is_private = (first == PrivNetA) ||
                 (first == PrivNetC0 && second == PrivNetC1) ||
                 (first == PrivNetB && second[7:4] == PrivNetBHi);
  endfunction

endpackage
`default_nettype wire

// File: rtl/ipv4_header_packet_filter.sv
// Top level of the IPv4 header packet filter: configuration registers and front/queue/back.
`default_nettype none
// IPv4 packet filter. Feed one packet byte per transfer on the input channel, starting at
// the first header byte, with last_byte high on the final byte; the outbound flag seen on
// that final byte sets the direction. Exactly one verdict transfer (drop_packet: 1 drop,
// 0 accept) follows each packet. Bytes are taken one per cycle while in_stall is low: the
// front captures fields per byte and hands a classified packet to a four-entry queue; the
// back resolves one packet per cycle into the output register unless out_stall holds it.
// in_stall rises only when the queue is full, i.e. when several verdicts are held back by
// out_stall. Configuration writes take effect on the next cycle and must only be issued
// while no packet is in flight; writes to indexes above five are ignored.
module ipv4_header_packet_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_outbound,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_drop_packet
);

  ipf_pkg::cfg_t       cfg_r, cfg_nxt;
  ipf_pkg::pkt_class_t push_data, pop_data;
  logic                q_push, q_full, q_pop, q_not_empty;

  // Register file: update the addressed register, mask to its width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ipf_pkg::CFG_BLOCKED_DEST:   cfg_nxt.blocked_dest    = cfg_wdata;
        ipf_pkg::CFG_THROTTLED_PORT: cfg_nxt.throttled_port  = cfg_wdata[15:0];
        ipf_pkg::CFG_BLOCKED_PORT:   cfg_nxt.blocked_port    = cfg_wdata[15:0];
        ipf_pkg::CFG_OUT_ECHO_PER:   cfg_nxt.out_echo_period = cfg_wdata[3:0];
        ipf_pkg::CFG_IN_ECHO_PER:    cfg_nxt.in_echo_period  = cfg_wdata[3:0];
        ipf_pkg::CFG_PORT_PER:       cfg_nxt.port_period     = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blocked_dest    <= ipf_pkg::RstBlockedDest;
      cfg_r.throttled_port  <= ipf_pkg::RstThrottledPort;
      cfg_r.blocked_port    <= ipf_pkg::RstBlockedPort;
      cfg_r.out_echo_period <= ipf_pkg::RstOutEchoPeriod;
      cfg_r.in_echo_period  <= ipf_pkg::RstInEchoPeriod;
      cfg_r.port_period     <= ipf_pkg::RstPortPeriod;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: capture bytes, push one classified entry per packet.
  ipf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_outbound  (in_outbound),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  // Queue: decouple capture from verdict delivery.
  ipf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  // Back: resolve rules, advance counters, hold the verdict for transfer.
  ipf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_not_empty     (q_not_empty),
    .q_data          (pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drop_packet (out_drop_packet)
  );

endmodule
`default_nettype wire

// File: rtl/ipf_front.sv
// Front end: capture header fields byte by byte and classify each finished packet.
`default_nettype none
module ipf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ipf_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_outbound,
  input  wire logic              in_last_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output ipf_pkg::pkt_class_t    q_data
);

  logic [5:0]  pos_r, pos_nxt;
  logic [3:0]  hw_r, hw_nxt, hw_c;
  logic [13:0] frag_r, frag_nxt, frag_c;
  logic [7:0]  proto_r, proto_nxt, proto_c;
  logic [15:0] src_r, src_nxt, src_c;
  logic [31:0] dst_r, dst_nxt, dst_c;
  logic [7:0]  mtype_r, mtype_nxt, mtype_c;
  logic [15:0] port_r, port_nxt, port_c;
  logic [5:0]  base;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign base     = (hw_r > ipf_pkg::MinHeaderWords) ? {hw_r, 2'b00} : ipf_pkg::MinHeaderBase;

  // Capture the current byte into the packet fields.
  always_comb begin
    hw_c    = hw_r;
    frag_c  = frag_r;
    proto_c = proto_r;
    src_c   = src_r;
    dst_c   = dst_r;
    mtype_c = mtype_r;
    port_c  = port_r;
    if (pos_r != ipf_pkg::LastPosition) begin
      case (pos_r)
        6'd0:  hw_c = in_data_byte[3:0];
        6'd6:  frag_c[13:8] = in_data_byte[5:0];
        6'd7:  frag_c[7:0] = in_data_byte;
        6'd9:  proto_c = in_data_byte;
        6'd12: src_c[15:8] = in_data_byte;
        6'd13: src_c[7:0] = in_data_byte;
        6'd16: dst_c[31:24] = in_data_byte;
        6'd17: dst_c[23:16] = in_data_byte;
        6'd18: dst_c[15:8] = in_data_byte;
        6'd19: dst_c[7:0] = in_data_byte;
        default: ;
      endcase
      if (pos_r == base) begin
        mtype_c = in_data_byte;
      end else if (pos_r == base + 6'd2) begin
        port_c[15:8] = in_data_byte;
      end else if (pos_r == base + 6'd3) begin
        port_c[7:0] = in_data_byte;
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    hw_nxt    = hw_r;
    frag_nxt  = frag_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    mtype_nxt = mtype_r;
    port_nxt  = port_r;
    q_push    = 1'b0;
    if (accept) begin
      if (in_last_byte) begin
        q_push    = 1'b1;
        pos_nxt   = '0;
        hw_nxt    = '0;
        frag_nxt  = '0;
        proto_nxt = '0;
        src_nxt   = '0;
        dst_nxt   = '0;
        mtype_nxt = '0;
        port_nxt  = '0;
      end else begin
        if (pos_r != ipf_pkg::LastPosition) begin
          pos_nxt = pos_r + 6'd1;
        end
        hw_nxt    = hw_c;
        frag_nxt  = frag_c;
        proto_nxt = proto_c;
        src_nxt   = src_c;
        dst_nxt   = dst_c;
        mtype_nxt = mtype_c;
        port_nxt  = port_c;
      end
    end
  end

  // Classify from the fields as they stand after the last byte.
  always_comb begin
    q_data.dst_blocked   = (dst_c == cfg.blocked_dest);
    q_data.loopback      = (dst_c[31:24] == ipf_pkg::LoopbackNet) ||
                           (src_c[15:8] == ipf_pkg::LoopbackNet);
    q_data.fragmented    = (frag_c != '0);
    q_data.icmp          = (proto_c == ipf_pkg::ProtoIcmp);
    q_data.bad_proto     = !q_data.icmp && (proto_c != ipf_pkg::ProtoTcp) &&
                           (proto_c != ipf_pkg::ProtoUdp);
    q_data.echo          = q_data.icmp && (mtype_c == ipf_pkg::IcmpEchoRequest);
    q_data.dst_private   = ipf_pkg::is_private(dst_c[31:24], dst_c[23:16]);
    q_data.src_private   = ipf_pkg::is_private(src_c[15:8], src_c[7:0]);
    q_data.hit_throttled = (port_c == cfg.throttled_port);
    q_data.hit_blocked   = (port_c == cfg.blocked_port);
    q_data.outbound      = in_outbound;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      hw_r    <= '0;
      frag_r  <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      mtype_r <= '0;
      port_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      hw_r    <= hw_nxt;
      frag_r  <= frag_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      mtype_r <= mtype_nxt;
      port_r  <= port_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ipf_queue.sv
// Short queue of classified packets between front and back.
`default_nettype none
module ipf_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ipf_pkg::pkt_class_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output ipf_pkg::pkt_class_t      pop_data
);

  ipf_pkg::pkt_class_t mem_r [ipf_pkg::QueueDepth];
  logic [ipf_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [ipf_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full      = (cnt_r == ipf_pkg::QCntW'(ipf_pkg::QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ipf_back.sv
// Back end: apply the ordered rules, run the period counters and hold the verdict.
`default_nettype none
module ipf_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ipf_pkg::cfg_t       cfg,
  input  wire logic                q_not_empty,
  input  wire ipf_pkg::pkt_class_t q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_drop_packet
);

  logic [3:0] oecnt_r, oecnt_nxt, iecnt_r, iecnt_nxt, pcnt_r, pcnt_nxt;
  logic [3:0] oe_inc, ie_inc, p_inc;
  logic       out_valid_r, out_valid_nxt;
  logic       drop_r, drop_nxt;
  logic       verdict;

  assign q_pop  = q_not_empty && (!out_valid_r || !out_stall);
  assign oe_inc = oecnt_r + 4'd1;
  assign ie_inc = iecnt_r + 4'd1;
  assign p_inc  = pcnt_r + 4'd1;

  always_comb begin
    oecnt_nxt = oecnt_r;
    iecnt_nxt = iecnt_r;
    pcnt_nxt  = pcnt_r;
    verdict   = 1'b0;
    if (q_data.dst_blocked) begin
      verdict = 1'b1;
    end else if (q_data.loopback) begin
      verdict = 1'b0;
    end else if (q_data.fragmented || q_data.bad_proto) begin
      verdict = 1'b1;
    end else if (q_data.echo && q_data.outbound && q_data.dst_private &&
                 oe_inc == cfg.out_echo_period) begin
      oecnt_nxt = '0;
      verdict   = 1'b1;
    end else if (q_data.echo && !q_data.outbound && q_data.src_private &&
                 ie_inc == cfg.in_echo_period) begin
      iecnt_nxt = '0;
      verdict   = 1'b1;
    end else begin
      // Echo counters advance without a hit.
      if (q_data.echo && q_data.outbound && q_data.dst_private) begin
        oecnt_nxt = oe_inc;
      end
      if (q_data.echo && !q_data.outbound && q_data.src_private) begin
        iecnt_nxt = ie_inc;
      end
      if (q_data.icmp) begin
        verdict = 1'b0;
      end else if (q_data.outbound && q_data.hit_throttled && p_inc == cfg.port_period) begin
        pcnt_nxt = '0;
        verdict  = 1'b1;
      end else begin
        if (q_data.outbound && q_data.hit_throttled) begin
          pcnt_nxt = p_inc;
        end
        verdict = q_data.outbound && q_data.hit_blocked;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    drop_nxt      = drop_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      drop_nxt      = verdict;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drop_packet = drop_r;

  always_ff @(posedge clk) begin
    drop_r <= drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      oecnt_r     <= '0;
      iecnt_r     <= '0;
      pcnt_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        oecnt_r <= oecnt_nxt;
        iecnt_r <= iecnt_nxt;
        pcnt_r  <= pcnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/ipv4_header_packet_filter_checker.sv
// Verdict checker for the IPv4 packet filter: watches all ports, predicts and compares verdicts.
module ipv4_header_packet_filter_checker
  import ipf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_outbound,
  input  wire logic        in_last_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_drop_packet,
  output int unsigned      verdicts_owed,
  output int unsigned      fail_count
);

  cfg_t        filter_cfg;
  logic [5:0]  byte_pos;
  logic [3:0]  ihl;
  logic [13:0] frag_word;
  logic [7:0]  proto;
  logic [15:0] src_prefix;
  logic [31:0] dst_ip;
  logic [7:0]  icmp_type;
  logic [15:0] dst_port;
  logic [3:0]  out_echo_cnt;
  logic [3:0]  in_echo_cnt;
  logic [3:0]  port_hits;
  logic        expected_drops[$];
  int unsigned errors = 0;

  task automatic flag_error(input string what);
    $display("[%0t] filter check: %s", $time, what);
    errors++;
  endtask

  function automatic logic private_net(input logic [7:0] first, input logic [7:0] second);
    return (first == PrivNetA) || (first == PrivNetC0 && second == PrivNetC1) ||
           (first == PrivNetB && second >= 8'd16 && second <= 8'd31);
  endfunction

  // Returns {period reached, new count}; the count clears when the period is reached.
  function automatic logic [4:0] period_step(input logic [3:0] count, input logic [3:0] period);
    logic [3:0] next;
    next = count + 4'd1;
    return (next == period) ? {1'b1, 4'd0} : {1'b0, next};
  endfunction

  task automatic clear_packet();
    byte_pos   = '0;
    ihl        = '0;
    frag_word  = '0;
    proto      = '0;
    src_prefix = '0;
    dst_ip     = '0;
    icmp_type  = '0;
    dst_port   = '0;
  endtask

  task automatic capture_byte(input logic [7:0] b);
    logic [6:0] base;
    // the transport header starts after the options, never before byte 20
    base = (ihl > MinHeaderWords) ? {1'b0, ihl, 2'b00} : 7'(MinHeaderBase);
    case (byte_pos)
      6'd0:  ihl = b[3:0];
      6'd6:  frag_word[13:8] = b[5:0];
      6'd7:  frag_word[7:0] = b;
      6'd9:  proto = b;
      6'd12: src_prefix[15:8] = b;
      6'd13: src_prefix[7:0] = b;
      6'd16: dst_ip[31:24] = b;
      6'd17: dst_ip[23:16] = b;
      6'd18: dst_ip[15:8] = b;
      6'd19: dst_ip[7:0] = b;
      default: ;
    endcase
    if ({1'b0, byte_pos} == base) icmp_type = b;
    else if ({1'b0, byte_pos} == base + 7'd2) dst_port[15:8] = b;
    else if ({1'b0, byte_pos} == base + 7'd3) dst_port[7:0] = b;
  endtask

  // Rules apply in order; the first one that decides ends the evaluation.
  task automatic judge_packet(input logic dir, output logic drop);
    logic       echo;
    logic       done;
    logic [4:0] step;
    echo = (proto == ProtoIcmp) && (icmp_type == IcmpEchoRequest);
    drop = 1'b0;
    done = 1'b1;
    if (dst_ip == filter_cfg.blocked_dest) drop = 1'b1;
    else if (dst_ip[31:24] == LoopbackNet || src_prefix[15:8] == LoopbackNet) drop = 1'b0;
    else if (frag_word != '0) drop = 1'b1;
    else if (proto != ProtoIcmp && proto != ProtoTcp && proto != ProtoUdp) drop = 1'b1;
    else done = 1'b0;
    if (!done && echo && dir && private_net(dst_ip[31:24], dst_ip[23:16])) begin
      step = period_step(out_echo_cnt, filter_cfg.out_echo_period);
      out_echo_cnt = step[3:0];
      drop = step[4];
      done = step[4];
    end
    if (!done && echo && !dir && private_net(src_prefix[15:8], src_prefix[7:0])) begin
      step = period_step(in_echo_cnt, filter_cfg.in_echo_period);
      in_echo_cnt = step[3:0];
      drop = step[4];
      done = step[4];
    end
    if (!done && proto == ProtoIcmp) done = 1'b1;
    if (!done && dir && dst_port == filter_cfg.throttled_port) begin
      step = period_step(port_hits, filter_cfg.port_period);
      port_hits = step[3:0];
      drop = step[4];
      done = step[4];
    end
    if (!done && dir && dst_port == filter_cfg.blocked_port) drop = 1'b1;
  endtask

  task automatic take_transfer(input logic [7:0] b, input logic dir, input logic fin);
    logic drop;
    if (byte_pos != LastPosition) begin
      capture_byte(b);
      byte_pos = byte_pos + 6'd1;
    end
    if (fin) begin
      judge_packet(dir, drop);
      expected_drops.push_back(drop);
      clear_packet();
    end
  endtask

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      filter_cfg = '{blocked_dest: RstBlockedDest, throttled_port: RstThrottledPort,
                     blocked_port: RstBlockedPort, out_echo_period: RstOutEchoPeriod,
                     in_echo_period: RstInEchoPeriod, port_period: RstPortPeriod};
      clear_packet();
      out_echo_cnt = '0;
      in_echo_cnt  = '0;
      port_hits    = '0;
      expected_drops.delete();
    end else begin
      // a verdict always belongs to a packet finished on an earlier edge
      if (out_valid && !out_stall) begin
        if (expected_drops.size() == 0) begin
          flag_error($sformatf("verdict %0b with no packet pending", out_drop_packet));
        end else begin
          want = expected_drops.pop_front();
          if (out_drop_packet !== want)
            flag_error($sformatf("drop_packet %0b, expected %0b", out_drop_packet, want));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCKED_DEST:   filter_cfg.blocked_dest = cfg_wdata;
          CFG_THROTTLED_PORT: filter_cfg.throttled_port = cfg_wdata[15:0];
          CFG_BLOCKED_PORT:   filter_cfg.blocked_port = cfg_wdata[15:0];
          CFG_OUT_ECHO_PER:   filter_cfg.out_echo_period = cfg_wdata[3:0];
          CFG_IN_ECHO_PER:    filter_cfg.in_echo_period = cfg_wdata[3:0];
          CFG_PORT_PER:       filter_cfg.port_period = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_transfer(in_data_byte, in_outbound, in_last_byte);
    end
    verdicts_owed <= expected_drops.size();
    fail_count    <= errors;
  end

endmodule

// File: tb/ipv4_header_packet_filter_test.sv
// Testbench top for the IPv4 packet filter: clock, reset, packet stimulus and the verdict.
module ipv4_header_packet_filter_test;
  import ipf_pkg::*;

  // Index past the last register; writes to it must leave every register alone.
  localparam logic [2:0] CfgUnused = 3'd7;
  localparam int unsigned PhaseBytes = 40;
  localparam int unsigned PhaseFrames = 2;
  localparam int unsigned HoldCycles = 120;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_outbound;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_drop_packet;

  int unsigned verdicts_owed;
  int unsigned fail_count;

  // Idle controls for the sender (gaps_on) and the receiver (stalls_on, hold_requests).
  logic        gaps_on;
  logic        stalls_on;
  int unsigned hold_requests;

  // Register values as last written, used to aim packets at the rules.
  logic [31:0] cur_blocked_dest;
  logic [15:0] cur_throttled_port;
  logic [15:0] cur_blocked_port;

  logic [7:0]  frame[$];
  int unsigned bytes_sent;
  int unsigned frames_sent;

  ipv4_header_packet_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_outbound    (in_outbound),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drop_packet(out_drop_packet)
  );

  ipv4_header_packet_filter_checker verdict_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_outbound    (in_outbound),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drop_packet(out_drop_packet),
    .verdicts_owed  (verdicts_owed),
    .fail_count     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: stall at random, and on each hold request keep the stall up for a long
  // stretch so the verdict queue fills and the block pushes back on its input.
  initial begin
    int unsigned seen;
    int unsigned hold;
    seen = 0;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && seen != hold_requests) begin
        seen = hold_requests;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= stalls_on && ($urandom_range(99) < 8);
      end
    end
  end

  // Offer one byte and hold it until the transfer happens; now and then idle first.
  task automatic send_byte(input logic [7:0] b, input logic dir, input logic fin);
    if (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_outbound  <= dir;
    in_last_byte <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Only the direction on the last byte counts; scramble it on the others.
  task automatic send_frame(input logic dir);
    for (int i = 0; i < frame.size(); i++) begin
      if (i == frame.size() - 1) send_byte(frame[i], dir, 1'b1);
      else send_byte(frame[i], 1'($urandom_range(1)), 1'b0);
    end
    frames_sent++;
  endtask

  // Build a packet of len bytes: random filler with the inspected fields placed on top.
  // Bytes past len are simply not sent, which makes a short packet.
  task automatic make_frame(input int ihl, input logic [13:0] frag, input logic [7:0] proto,
                            input logic [15:0] src, input logic [31:0] dst,
                            input logic [7:0] mtype, input logic [15:0] port, input int len);
    logic [7:0] hdr [0:79];
    int base;
    for (int i = 0; i < 80; i++) hdr[i] = 8'($urandom);
    base = (ihl > 5) ? ihl * 4 : 20;
    hdr[0]  = {hdr[0][7:4], 4'(ihl)};
    hdr[6]  = {hdr[6][7:6], frag[13:8]};
    hdr[7]  = frag[7:0];
    hdr[9]  = proto;
    hdr[12] = src[15:8];
    hdr[13] = src[7:0];
    hdr[16] = dst[31:24];
    hdr[17] = dst[23:16];
    hdr[18] = dst[15:8];
    hdr[19] = dst[7:0];
    hdr[base]     = mtype;
    hdr[base + 2] = port[15:8];
    hdr[base + 3] = port[7:0];
    frame.delete();
    for (int i = 0; i < len; i++) frame.push_back(hdr[i]);
  endtask

  // Pick a /16 prefix: mostly private ranges, loopback, or the near misses around them.
  function automatic logic [15:0] pick_prefix();
    case ($urandom_range(5))
      0: return {PrivNetA, 8'($urandom)};
      1: return {PrivNetB, 8'($urandom_range(16, 31))};
      2: return {PrivNetB, 8'($urandom)};
      3: return {PrivNetC0, PrivNetC1};
      4: return {LoopbackNet, 8'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed headers aimed at the rules; some options, fragments,
  // odd protocols, truncated packets and packets running past byte 63.
  task automatic random_frame(output logic dir, input int max_len);
    int          ihl;
    int          base;
    int          len;
    int          roll;
    logic [13:0] frag;
    logic [7:0]  proto;
    logic [7:0]  mtype;
    logic [31:0] dst;
    logic [15:0] port;
    roll = $urandom_range(99);
    ihl  = (roll < 70) ? 5 : (roll < 90) ? $urandom_range(6, 15) : $urandom_range(0, 4);
    frag = ($urandom_range(99) < 88) ? 14'd0 : 14'($urandom);
    roll = $urandom_range(99);
    proto = (roll < 35) ? ProtoIcmp : (roll < 65) ? ProtoTcp :
            (roll < 92) ? ProtoUdp : 8'($urandom);
    dst = ($urandom_range(99) < 10) ? cur_blocked_dest : {pick_prefix(), 16'($urandom)};
    mtype = (proto == ProtoIcmp && $urandom_range(99) < 70) ? IcmpEchoRequest : 8'($urandom);
    roll = $urandom_range(99);
    port = (roll < 35) ? cur_throttled_port : (roll < 60) ? cur_blocked_port : 16'($urandom);
    base = (ihl > 5) ? ihl * 4 : 20;
    roll = $urandom_range(99);
    if (roll < 12) len = $urandom_range(1, base + 3);
    else if (roll < 18) len = $urandom_range(60, 70);
    else len = base + 4 + $urandom_range(0, 6);
    if (len > max_len) len = $urandom_range(1, max_len);
    dir = 1'($urandom_range(1));
    make_frame(ihl, frag, proto, pick_prefix(), dst, mtype, port, len);
  endtask

  task automatic run_traffic();
    int unsigned start_bytes;
    int unsigned start_frames;
    logic dir;
    start_bytes  = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < PhaseBytes || frames_sent - start_frames < PhaseFrames)
    begin
      random_frame(dir, 80);
      send_frame(dir);
    end
  endtask

  // Drop valid, wait until every verdict is in, then let the pipeline go quiet.
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Program every register (upper bits carry junk to exercise masking), plus one
  // write to an unused index; release the write enable afterwards.
  task automatic configure(input logic [31:0] bdst, input logic [31:0] tport,
                           input logic [31:0] bport, input logic [31:0] out_per,
                           input logic [31:0] in_per, input logic [31:0] port_per);
    write_reg(CFG_BLOCKED_DEST, bdst);
    write_reg(CFG_THROTTLED_PORT, tport);
    write_reg(CFG_BLOCKED_PORT, bport);
    write_reg(CFG_OUT_ECHO_PER, out_per);
    write_reg(CFG_IN_ECHO_PER, in_per);
    write_reg(CFG_PORT_PER, port_per);
    write_reg(CfgUnused, 32'($urandom));
    cfg_we <= 1'b0;
    cur_blocked_dest   = bdst;
    cur_throttled_port = tport[15:0];
    cur_blocked_port   = bport[15:0];
  endtask

  // A period in range 1..15 with random junk above the low nibble.
  function automatic logic [31:0] junk_period();
    return {28'($urandom), 4'($urandom_range(1, 15))};
  endfunction

  initial begin
    logic dir;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_outbound  <= 1'b0;
    in_last_byte <= 1'b0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    hold_requests = 0;
    bytes_sent    = 0;
    frames_sent   = 0;
    cur_blocked_dest   = RstBlockedDest;
    cur_throttled_port = RstThrottledPort;
    cur_blocked_port   = RstBlockedPort;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets against the reset settings.
    // blocked destination beats everything
    make_frame(5, 14'd0, ProtoTcp, 16'h0A00, RstBlockedDest, 8'd0, RstThrottledPort, 24);
    send_frame(1'b1);
    // loopback destination accepted despite a fragment and a bad protocol
    make_frame(5, 14'h0001, 8'hFF, 16'hC0A8, {LoopbackNet, 24'h000001}, 8'd0, 16'd0, 20);
    send_frame(1'b0);
    // loopback source
    make_frame(5, 14'h2000, ProtoUdp, {LoopbackNet, 8'd0}, 32'h0102_0304, 8'd0, 16'd0, 24);
    send_frame(1'b1);
    // more-fragments flag, then offset only
    make_frame(5, 14'h2000, ProtoUdp, 16'h0102, 32'h0506_0708, 8'd0, 16'd53, 24);
    send_frame(1'b0);
    make_frame(5, 14'h1FFF, ProtoTcp, 16'h0102, 32'h0506_0708, 8'd0, 16'd22, 24);
    send_frame(1'b1);
    // protocol outside ICMP/TCP/UDP
    make_frame(5, 14'd0, 8'd50, 16'h0102, 32'h0506_0708, 8'd0, 16'd22, 24);
    send_frame(1'b0);
    // outgoing echo requests to 192.168/16: every third drops
    repeat (3) begin
      make_frame(5, 14'd0, ProtoIcmp, 16'h0102, {PrivNetC0, PrivNetC1, 16'h0001},
                 IcmpEchoRequest, 16'd0, 28);
      send_frame(1'b1);
    end
    // incoming echo requests from 172.31/16: every fourth drops
    repeat (4) begin
      make_frame(5, 14'd0, ProtoIcmp, {PrivNetB, 8'd31}, 32'h0102_0304,
                 IcmpEchoRequest, 16'd0, 28);
      send_frame(1'b0);
    end
    // other ICMP passes
    make_frame(5, 14'd0, ProtoIcmp, 16'h0A01, 32'h0A00_0001, 8'd0, 16'd0, 28);
    send_frame(1'b1);
    // throttled port: every second outgoing packet drops
    repeat (2) begin
      make_frame(5, 14'd0, ProtoTcp, 16'h0102, 32'h0506_0708, 8'd0, RstThrottledPort, 40);
      send_frame(1'b1);
    end
    // blocked port: outgoing drops, incoming passes
    make_frame(5, 14'd0, ProtoUdp, 16'h0102, 32'h0506_0708, 8'd0, RstBlockedPort, 24);
    send_frame(1'b1);
    make_frame(5, 14'd0, ProtoUdp, 16'h0102, 32'h0506_0708, 8'd0, RstBlockedPort, 24);
    send_frame(1'b0);
    // all-zero fields, then a one-byte packet where everything reads as zero
    make_frame(0, 14'd0, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 24);
    send_frame(1'b0);
    make_frame(0, 14'd0, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 1);
    send_frame(1'b1);
    // all-ones fields
    make_frame(15, 14'h3FFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 64);
    send_frame(1'b1);
    // 15-word header: the low port byte sits at position 63 and is never captured,
    // so the blocked port must not match
    make_frame(15, 14'd0, ProtoTcp, 16'h0102, 32'h0506_0708, 8'd0, RstBlockedPort, 70);
    send_frame(1'b1);

    // Extremes: blocked destination zero, port zero, all-ones blocked port, period one.
    // Open with a long output hold while tiny packets keep coming.
    drain_verdicts();
    configure(32'h0000_0000, 32'hA5A5_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF1, 32'h0000_0011,
              32'h1234_5671);
    hold_requests++;
    gaps_on = 1'b0;
    repeat (16) begin
      random_frame(dir, 3);
      send_frame(dir);
    end
    gaps_on = 1'b1;
    run_traffic();

    // Other extremes, with neither side idling for the whole phase.
    drain_verdicts();
    configure(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h1234_0000, 32'h0000_000F, 32'hFFFF_FFFF,
              32'h8000_000F);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_traffic();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // Random settings; ports sometimes back on the familiar web ports.
    repeat (2) begin
      drain_verdicts();
      configure(($urandom_range(1)) ? 32'($urandom) : RstBlockedDest,
                ($urandom_range(1)) ? 32'($urandom) : 32'(RstThrottledPort),
                ($urandom_range(1)) ? 32'($urandom) : 32'(RstBlockedPort),
                junk_period(), junk_period(), junk_period());
      run_traffic();
    end

    drain_verdicts();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ipf_pkg.sv
rtl/ipf_front.sv
rtl/ipf_queue.sv
rtl/ipf_back.sv
rtl/ipv4_header_packet_filter.sv
tb/ipv4_header_packet_filter_checker.sv
tb/ipv4_header_packet_filter_test.sv
